// ===== rtl/core/metl_pkg.sv =====
// Shared types and constants for the escape-time lanes block.
`default_nettype none
package metl_pkg;
  localparam int FRAC_BITS = 24;
  localparam int CNT_W = 11;
  localparam int PIX_W = 10;

  typedef enum logic [2:0] {
    REG_CENTER_RE = 3'd0,
    REG_CENTER_IM = 3'd1,
    REG_SCALE     = 3'd2,
    REG_STEP_X    = 3'd3,
    REG_STEP_Y    = 3'd4,
    REG_ESC_SQ    = 3'd5,
    REG_MAX_ITER  = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MAP,
    ST_ITER,
    ST_OUT
  } state_t;

  // Lane control from the sequencer.
  typedef struct packed {
    logic load;
    logic iter;
  } lane_ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) sat32 = 32'sh7fffffff;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/mandelbrot_escape_time_lanes_unit.sv =====
// Top level: sequencer, pixel mapping, lane array and result serialiser.
// Sequence after the accepting edge: two setup states, ST_STEP (step products) and ST_MAP (mapping
// and lane load), then ST_ITER rounds up to min(max_iterations, ITER_LIMIT) rounds (stops early once
// every lane has escaped) plus a final ST_ITER check that sees the end, then LANES result transactions.
// One run is in flight at a time: a new request is accepted only in ST_IDLE, after the last result
// transaction of the previous run. Synchronous reset clears control state and loads the
// register reset values.
`default_nettype none
module mandelbrot_escape_time_lanes_unit
  import metl_pkg::*;
#(
  parameter int LANES = 16,
  parameter int WIDTH = 1024,
  parameter int HEIGHT = 1024,
  parameter int ITER_LIMIT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // start_column[9:0], row[19:10]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // pixel_x[9:0], pixel_y[19:10], iteration_count[30:20]
  output logic             m_tlast
);
  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int RW = $clog2(ITER_LIMIT + 1);

  logic signed [31:0] center_re, center_im;
  logic [30:0] scale, step_x, step_y, esc_sq;
  logic [10:0] max_iter;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_re <= -32'sd8388608;
      center_im <= '0;
      scale <= 31'd16777216;
      step_x <= 31'd49152;
      step_y <= 31'd49152;
      esc_sq <= 31'd67108864;
      max_iter <= 11'd256;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CENTER_RE: center_re <= cfg_data;
        REG_CENTER_IM: center_im <= cfg_data;
        REG_SCALE:     scale <= cfg_data[30:0];
        REG_STEP_X:    step_x <= cfg_data[30:0];
        REG_STEP_Y:    step_y <= cfg_data[30:0];
        REG_ESC_SQ:    esc_sq <= cfg_data[30:0];
        REG_MAX_ITER:  max_iter <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic [PIX_W-1:0] col0, rowv;
  logic [30:0] dx, dy;
  logic [RW-1:0] rnd, limit;
  logic [LW-1:0] oidx;
  logic [LANES-1:0] act;
  logic [CNT_W-1:0] cnt [LANES];
  logic signed [31:0] c_re [LANES];
  logic signed [31:0] c_im;
  lane_ctrl_t ctrl;

  // Pixel step products, registered in ST_STEP.
  logic [61:0] pdx, pdy;
  logic [37:0] sdx, sdy;
  always_comb begin
    pdx = 62'(step_x) * 62'(scale);
    pdy = 62'(step_y) * 62'(scale);
    sdx = pdx[61:FRAC_BITS];
    sdy = pdy[61:FRAC_BITS];
  end

  // Mapping: (pos - half) * d + centre, saturated.
  logic signed [63:0] im_prod;
  always_comb begin
    im_prod = ($signed({2'b0, rowv}) - 64'(HEIGHT / 2)) * $signed({1'b0, dy});
    c_im = sat32(66'(im_prod) + 66'(center_im));
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [63:0] re_prod;
    always_comb begin
      re_prod = (64'(col0) + 64'(i) - 64'(WIDTH / 2)) * $signed({33'b0, dx});
      c_re[i] = sat32(66'(re_prod) + 66'(center_re));
    end
    metl_lane u_lane (
      .clk(clk), .rst(rst), .ctrl(ctrl), .c_re_in(c_re[i]), .c_im_in(c_im),
      .esc_sq(esc_sq), .active(act[i]), .count(cnt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      col0 <= s_tdata[9:0];
      rowv <= s_tdata[19:10];
    end
    if (state == ST_STEP) begin
      dx <= (sdx > 38'h7fffffff) ? 31'h7fffffff : sdx[30:0];
      dy <= (sdy > 38'h7fffffff) ? 31'h7fffffff : sdy[30:0];
      limit <= (32'(max_iter) > 32'(ITER_LIMIT)) ? RW'(ITER_LIMIT) : RW'(max_iter);
    end
    if (state == ST_MAP) rnd <= '0;
    else if (state == ST_ITER) rnd <= rnd + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) oidx <= '0;
    else if (state == ST_OUT && m_tready) oidx <= oidx + 1'b1;
    else if (state != ST_OUT) oidx <= '0;
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    s_tready = (state == ST_IDLE);
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_STEP;
      ST_STEP: state_next = ST_MAP;
      ST_MAP: begin
        ctrl.load = 1'b1;
        state_next = ST_ITER;
      end
      ST_ITER: begin
        // stop at the limit or once every lane has escaped
        if (rnd >= limit || act == '0) state_next = ST_OUT;
        else ctrl.iter = 1'b1;
      end
      ST_OUT: if (m_tready && 32'(oidx) == LANES - 1) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  logic [PIX_W-1:0] px;
  always_comb begin
    px = col0 + PIX_W'(oidx);
    m_tvalid = (state == ST_OUT);
    m_tdata = {1'b0, cnt[oidx], rowv, px};
    m_tlast = (32'(oidx) == LANES - 1);
  end
endmodule
`default_nettype wire

// ===== rtl/core/metl_lane.sv =====
// One escape-time lane: holds z and c, performs one iteration round per step.
`default_nettype none
module metl_lane
  import metl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire lane_ctrl_t               ctrl,
  input  wire logic signed [31:0]       c_re_in,
  input  wire logic signed [31:0]       c_im_in,
  input  wire logic        [30:0]       esc_sq,
  output logic                          active,
  output logic             [CNT_W-1:0]  count
);
  logic signed [31:0] z_re, z_im, c_re, c_im;
  logic signed [63:0] x2p, y2p, xyp;
  logic signed [39:0] x2, y2, xy;
  logic signed [65:0] mag, nre, nim;
  logic escape;

  always_comb begin
    x2p = z_re * z_re;
    y2p = z_im * z_im;
    xyp = z_re * z_im;
    // arithmetic shift floors toward minus infinity
    x2 = 40'(x2p >>> FRAC_BITS);
    y2 = 40'(y2p >>> FRAC_BITS);
    xy = 40'(xyp >>> FRAC_BITS);
    mag = 66'(x2) + 66'(y2);
    escape = mag > $signed({35'd0, esc_sq});
    nre = 66'(x2) - 66'(y2) + 66'(c_re);
    nim = 66'(xy) + 66'(xy) + 66'(c_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      count <= '0;
    end else if (ctrl.load) begin
      active <= 1'b1;
      count <= '0;
    end else if (ctrl.iter && active) begin
      if (escape) active <= 1'b0;
      else count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      z_re <= c_re_in;
      z_im <= c_im_in;
      c_re <= c_re_in;
      c_im <= c_im_in;
    end else if (ctrl.iter && active && !escape) begin
      z_re <= sat32(nre);
      z_im <= sat32(nim);
    end
  end
endmodule
`default_nettype wire
